### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro names its assertion, samples on the rising edge of clk and
// is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/osir_pkg.sv
// ---------------------------------------------------------------------------
// osir_pkg
// Types, sizes and codes shared by the ordered set controller and datapath.
// ---------------------------------------------------------------------------
package osir_pkg;

  // Set capacity and element width
  localparam int CAPACITY   = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W      = $clog2(CAPACITY + 1);

  // Fixed widths of the port fields
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [OCC_W-1:0]      occ_t;

  // Command codes
  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } command_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_PRESENT = 3'd1,
    ST_REMOVED = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // Update operation applied to the cell row
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_APPEND = 2'd1,
    OP_SHIFT  = 2'd2
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_UPDATE = 2'd2,
    S_REPORT = 2'd3
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    search;
    op_t     op;
    logic    set_code;
    status_t code;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic remove;
    logic hit;
    logic full;
  } dp_stat_t;

endpackage

### hdl/osir_ctrl.sv
// ---------------------------------------------------------------------------
// osir_ctrl
// Command sequencer: load, search, update, report; picks the operation and
// the status code from the search outcome.
// ---------------------------------------------------------------------------
module osir_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  osir_pkg::dp_stat_t stat,
  output osir_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);

  osir_pkg::state_t state_r, state_nxt;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= osir_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through the command sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      osir_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = osir_pkg::S_SEARCH;
        end
      end
      osir_pkg::S_SEARCH: state_nxt = osir_pkg::S_UPDATE;
      osir_pkg::S_UPDATE: state_nxt = osir_pkg::S_REPORT;
      osir_pkg::S_REPORT: state_nxt = osir_pkg::S_IDLE;
      default:            state_nxt = osir_pkg::S_IDLE;
    endcase
  end

  // Drive datapath commands and handshake outputs
  always_comb begin
    cmd          = '0;
    cmd.op       = osir_pkg::OP_NONE;
    cmd.code     = osir_pkg::ST_ADDED;
    busy         = 1'b1;
    out_valid    = 1'b0;
    unique case (state_r)
      osir_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      osir_pkg::S_SEARCH: begin
        cmd.search = 1'b1;
      end
      osir_pkg::S_UPDATE: begin
        cmd.set_code = 1'b1;
        priority if (stat.remove && stat.hit) begin
          cmd.op   = osir_pkg::OP_SHIFT;
          cmd.code = osir_pkg::ST_REMOVED;
        end else if (stat.remove) begin
          cmd.code = osir_pkg::ST_ABSENT;
        end else if (stat.hit) begin
          cmd.code = osir_pkg::ST_PRESENT;
        end else if (stat.full) begin
          cmd.code = osir_pkg::ST_FULL;
        end else begin
          cmd.op   = osir_pkg::OP_APPEND;
          cmd.code = osir_pkg::ST_ADDED;
        end
      end
      osir_pkg::S_REPORT: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### hdl/osir_dpath.sv
// ---------------------------------------------------------------------------
// osir_dpath
// Row of element cells with parallel match, append at the tail and
// compacting shift on removal; holds the occupancy and the result status.
// ---------------------------------------------------------------------------
module osir_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  osir_pkg::dp_cmd_t                   cmd,
  input  logic                                in_command,
  input  logic [osir_pkg::VALUE_W-1:0]        in_value,
  output osir_pkg::dp_stat_t                  stat,
  output logic [osir_pkg::STATUS_W-1:0]       out_status,
  output logic [osir_pkg::COUNT_W-1:0]        out_count
);

  osir_pkg::elem_t   cells_r [osir_pkg::CAPACITY];
  osir_pkg::elem_t   value_r;
  logic              remove_r;
  osir_pkg::occ_t    occ_r;
  logic              hit_r;
  osir_pkg::idx_t    pos_r;
  osir_pkg::status_t status_r;

  logic [osir_pkg::CAPACITY-1:0] match;
  logic                          hit_nxt;
  osir_pkg::idx_t                pos_nxt;

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r  <= osir_pkg::elem_t'(in_value);
      remove_r <= (in_command == osir_pkg::CMD_REMOVE);
    end
  end

  // Compare every held cell against the value
  always_comb begin
    for (int i = 0; i < osir_pkg::CAPACITY; i++) begin
      match[i] = (osir_pkg::OCC_W'(i) < occ_r) && (cells_r[i] == value_r);
    end
  end

  // Pick the lowest matching cell
  always_comb begin
    hit_nxt = |match;
    pos_nxt = '0;
    for (int i = osir_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos_nxt = osir_pkg::IDX_W'(i);
      end
    end
  end

  // Register the search outcome
  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_r <= hit_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Append at the tail or close the gap left by a removal
  always_ff @(posedge clk) begin
    for (int i = 0; i < osir_pkg::CAPACITY; i++) begin
      if (cmd.op == osir_pkg::OP_APPEND && osir_pkg::OCC_W'(i) == occ_r) begin
        cells_r[i] <= value_r;
      end else if (cmd.op == osir_pkg::OP_SHIFT && i < osir_pkg::CAPACITY - 1 &&
                   osir_pkg::IDX_W'(i) >= pos_r) begin
        cells_r[i] <= cells_r[(i + 1) % osir_pkg::CAPACITY];
      end
    end
  end

  // Track the occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      unique case (cmd.op)
        osir_pkg::OP_APPEND: occ_r <= occ_r + osir_pkg::OCC_W'(1);
        osir_pkg::OP_SHIFT:  occ_r <= occ_r - osir_pkg::OCC_W'(1);
        default:             occ_r <= occ_r;
      endcase
    end
  end

  // Hold the status of the finished command
  always_ff @(posedge clk) begin
    if (cmd.set_code) begin
      status_r <= cmd.code;
    end
  end

  assign stat.remove = remove_r;
  assign stat.hit    = hit_r;
  assign stat.full   = (occ_r == osir_pkg::OCC_W'(osir_pkg::CAPACITY));

  assign out_status = status_r;
  assign out_count  = osir_pkg::COUNT_W'(occ_r);

endmodule

### hdl/ordered_set_insert_remove.sv
// ---------------------------------------------------------------------------
// ordered_set_insert_remove
// Set of distinct values kept in insertion order, with add and remove.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_command (0 add, 1 remove) and in_value with
//   start high; the beat is taken at a rising edge where busy is low.
//   Result channel: out_status and out_count are shown for one cycle with
//   out_valid high; the receiver cannot stall and must take them then.
//   The result follows the command through the search state (parallel
//   match over all cells), the update state (append at the tail or
//   compacting shift) and the report state. The sequencer takes no new
//   command until the last one is through: it holds busy high from
//   acceptance until the result cycle has passed.
//   An add of a new value to a full set is dropped with a full status.
//   Reset (rst_n low, synchronous) empties the set and returns the
//   sequencer to idle; cell contents are not cleared, since only cells
//   below the occupancy are ever compared.
// ---------------------------------------------------------------------------
module ordered_set_insert_remove (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [osir_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  output logic [osir_pkg::STATUS_W-1:0] out_status,
  output logic [osir_pkg::COUNT_W-1:0]  out_count
);

  osir_pkg::dp_cmd_t  cmd;
  osir_pkg::dp_stat_t stat;

  // Sequence each command
  osir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Hold and update the cell row
  osir_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_command (in_command),
    .in_value   (in_value),
    .stat       (stat),
    .out_status (out_status),
    .out_count  (out_count)
  );

endmodule

### hdl/osir_checker.sv
// ---------------------------------------------------------------------------
// osir_checker
// Port-level checks on command acceptance and result timing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module osir_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // A taken command makes the block busy
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "busy low after command beat")

  // A taken command is followed by its result beat
  `ASSERT_CLK(a_result_latency, (start && !busy) |-> ##3 out_valid, "result beat missing")

  // A result beat lasts one cycle
  `ASSERT_CLK(a_single_strobe, out_valid |=> !out_valid, "result strobe held")

  // No result beat while idle
  `ASSERT_NEVER(a_idle_result, out_valid && !busy, "result beat while idle")

endmodule

bind ordered_set_insert_remove osir_checker u_osir_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
